### rtl/ttg_pkg.sv
// Shared types and constants for the trapezoidal time-to-goal unit.
// Depends on nothing; every other file imports it.
package ttg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int QW        = 32;               // data and time word width
	localparam int REG_W     = 31;               // configuration register width
	localparam int CFG_IDX_W = 2;
	localparam int RAD_W     = 64;               // radicand width
	localparam int SQ_STEPS  = RAD_W / 2;        // one root bit per stage
	localparam int NUM_W     = 65;               // dividend before scaling
	localparam int DEN_W     = 63;
	localparam int DIV_STEPS = QW;               // one quotient bit per stage

	localparam logic [QW-1:0] ONE_Q    = 32'd1 << FRAC_BITS;
	localparam logic [QW-1:0] TIME_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TOWARD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_AWAY   = 2'd2;

	typedef enum logic [2:0] {
		K_ZERO,
		K_FALLBACK,
		K_LINEAR,
		K_BELOW_POS,
		K_BELOW_NEG,
		K_TOP
	} ttg_kind_t;

	typedef struct packed {
		logic signed [QW-1:0] distance;
		logic signed [QW-1:0] speed;
	} ttg_in_t;

	typedef struct packed {
		logic [QW-1:0] time_to_goal;
		logic          fallback_used;
		logic          saturated;
	} ttg_out_t;

	typedef struct packed {
		ttg_kind_t          kind;
		logic [QW-1:0]      ux;
		logic [QW-1:0]      mag;
		logic [REG_W-1:0]   accel;
		logic [NUM_W-1:0]   top_num;
		logic [DEN_W-1:0]   top_den;
	} ttg_ctx_t;

endpackage

### rtl/ttg_front.sv
// Front end: mirroring, top-speed clamp, products and case selection (three stages).
// Depends on ttg_pkg.
module ttg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_in,
	input  ttg_pkg::ttg_in_t          word_in,
	input  logic [ttg_pkg::REG_W-1:0] max_speed,
	input  logic [ttg_pkg::REG_W-1:0] accel_toward,
	input  logic [ttg_pkg::REG_W-1:0] accel_away,
	output logic                      vld_out,
	output ttg_pkg::ttg_ctx_t         ctx_out,
	output logic [ttg_pkg::RAD_W-1:0] rad_out
);
	import ttg_pkg::*;

	// stage 1 logic
	logic            neg, zero;
	logic [QW:0]     x33, sp33, v33, mag33;
	logic            vpos, vneg;
	logic [QW-1:0]   mag, v1raw, v1, dv;
	logic [REG_W-1:0] acc;

	logic            vld_s1, zero_s1, vpos_s1, vneg_s1;
	logic [QW-1:0]   ux_s1, mag_s1, v1_s1, dv_s1;
	logic [REG_W-1:0] acc_s1;

	logic            vld_s2, zero_s2, vpos_s2, vneg_s2, accz_s2;
	logic [QW-1:0]   ux_s2, mag_s2;
	logic [REG_W-1:0] acc_s2;
	logic [63:0]     magsq_s2, v1sq_s2, dvsq_s2;
	logic [62:0]     ax_s2, av1_s2;

	logic [63:0]     s_sum;
	logic [64:0]     lo_sum;
	logic            below;
	ttg_kind_t       kind;

	logic            vld_s3;
	ttg_ctx_t        ctx_s3;
	logic [RAD_W-1:0] rad_s3;

	always_comb begin
		neg   = word_in.distance[QW-1];
		zero  = (word_in.distance == '0);
		x33   = {word_in.distance[QW-1], word_in.distance};
		if (neg) x33 = -x33;
		sp33  = {word_in.speed[QW-1], word_in.speed};
		v33   = neg ? -sp33 : sp33;
		vneg  = v33[QW];
		vpos  = !v33[QW] && (v33 != '0);
		mag33 = vneg ? -v33 : v33;
		mag   = mag33[QW-1:0];
		acc   = neg ? accel_away : accel_toward;
		// raise the top speed to a higher positive current speed, a zero top speed becomes 1.0
		v1raw = (vpos && (mag > {1'b0, max_speed})) ? mag : {1'b0, max_speed};
		v1    = (v1raw == '0) ? ONE_Q : v1raw;
		dv    = vneg ? v1 + mag : v1 - mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= zero;
			vpos_s1 <= vpos;
			vneg_s1 <= vneg;
			ux_s1   <= x33[QW-1:0];
			mag_s1  <= mag;
			acc_s1  <= acc;
			v1_s1   <= v1;
			dv_s1   <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2  <= zero_s1;
			vpos_s2  <= vpos_s1;
			vneg_s2  <= vneg_s1;
			accz_s2  <= (acc_s1 == '0);
			ux_s2    <= ux_s1;
			mag_s2   <= mag_s1;
			acc_s2   <= acc_s1;
			magsq_s2 <= mag_s1 * mag_s1;
			v1sq_s2  <= v1_s1 * v1_s1;
			dvsq_s2  <= dv_s1 * dv_s1;
			ax_s2    <= acc_s1 * ux_s1;
			av1_s2   <= acc_s1 * v1_s1;
		end
	end

	always_comb begin
		s_sum  = magsq_s2 + {ax_s2, 1'b0};
		lo_sum = {1'b0, dvsq_s2} + {1'b0, ax_s2, 1'b0};
		below  = (s_sum <= v1sq_s2);
		if (zero_s2)
			kind = K_ZERO;
		else if (accz_s2)
			kind = vpos_s2 ? K_LINEAR : K_FALLBACK;
		else if (below)
			kind = vneg_s2 ? K_BELOW_NEG : K_BELOW_POS;
		else
			kind = K_TOP;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3.kind    <= kind;
			ctx_s3.ux      <= ux_s2;
			ctx_s3.mag     <= mag_s2;
			ctx_s3.accel   <= acc_s2;
			ctx_s3.top_num <= lo_sum;
			ctx_s3.top_den <= {av1_s2[DEN_W-2:0], 1'b0};
			rad_s3         <= s_sum;
		end
	end

	assign vld_out = vld_s3;
	assign ctx_out = ctx_s3;
	assign rad_out = rad_s3;

endmodule

### rtl/ttg_sqrt.sv
// Pipelined integer square root, one root bit per stage, context carried alongside.
// Depends on ttg_pkg.
module ttg_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_in,
	input  ttg_pkg::ttg_ctx_t         ctx_in,
	input  logic [ttg_pkg::RAD_W-1:0] rad_in,
	output logic                      vld_out,
	output ttg_pkg::ttg_ctx_t         ctx_out,
	output logic [ttg_pkg::QW-1:0]    root_out
);
	import ttg_pkg::*;

	logic [SQ_STEPS-1:0] vld_s;
	ttg_ctx_t            ctx_s  [SQ_STEPS];
	logic [RAD_W-1:0]    rad_s  [SQ_STEPS];
	logic [RAD_W-1:0]    root_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = 64'd1 << (RAD_W - 2 - 2 * k);
		logic             vld_cur;
		ttg_ctx_t         ctx_cur;
		logic [RAD_W-1:0] n_cur, r_cur, trial, n_nxt, r_nxt;
		logic [RAD_W:0]   diff;

		if (k == 0) begin : g_head
			assign vld_cur = vld_in;
			assign ctx_cur = ctx_in;
			assign n_cur   = rad_in;
			assign r_cur   = '0;
		end else begin : g_body
			assign vld_cur = vld_s[k-1];
			assign ctx_cur = ctx_s[k-1];
			assign n_cur   = rad_s[k-1];
			assign r_cur   = root_s[k-1];
		end

		always_comb begin
			trial = r_cur | BIT;
			diff  = {1'b0, n_cur} - {1'b0, trial};
			if (!diff[RAD_W]) begin
				n_nxt = diff[RAD_W-1:0];
				r_nxt = (r_cur >> 1) | BIT;
			end else begin
				n_nxt = n_cur;
				r_nxt = r_cur >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_cur;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k]  <= ctx_cur;
				rad_s[k]  <= n_nxt;
				root_s[k] <= r_nxt;
			end
		end
	end

	assign vld_out  = vld_s[SQ_STEPS-1];
	assign ctx_out  = ctx_s[SQ_STEPS-1];
	assign root_out = root_s[SQ_STEPS-1][QW-1:0];

endmodule

### rtl/ttg_div.sv
// Operand select, range check, pipelined restoring division and result register.
// Depends on ttg_pkg.
module ttg_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_in,
	input  ttg_pkg::ttg_ctx_t      ctx_in,
	input  logic [ttg_pkg::QW-1:0] root_in,
	output logic                   vld_out,
	output ttg_pkg::ttg_out_t      word_out
);
	import ttg_pkg::*;

	localparam int NW = NUM_W + FRAC_BITS;

	logic [QW:0]        rsum;
	logic [NUM_W-1:0]   num;
	logic [DEN_W-1:0]   den;

	logic               vld_s1;
	ttg_kind_t          kind_s1;
	logic [NUM_W-1:0]   num_s1;
	logic [DEN_W-1:0]   den_s1;

	logic [NW-1:0]      nscaled;
	logic [NW-QW-1:0]   nhigh;

	logic               vld_s2, sat_s2;
	ttg_kind_t          kind_s2;
	logic [DEN_W-1:0]   den_s2;
	logic [63:0]        rem_s2;
	logic [QW-1:0]      low_s2;

	logic [DIV_STEPS-1:0] vld_s;
	logic [DIV_STEPS-1:0] sat_s;
	ttg_kind_t          kind_s [DIV_STEPS];
	logic [DEN_W-1:0]   den_s  [DIV_STEPS];
	logic [63:0]        rem_s  [DIV_STEPS];
	logic [QW-1:0]      quo_s  [DIV_STEPS];
	logic [QW-1:0]      low_s  [DIV_STEPS];

	logic               vld_q;
	ttg_out_t           out_q;
	ttg_out_t           res;

	always_comb begin
		rsum = {1'b0, root_in} + {1'b0, ctx_in.mag};
		case (ctx_in.kind)
			K_LINEAR: begin
				num = NUM_W'(ctx_in.ux);
				den = DEN_W'(ctx_in.mag);
			end
			K_BELOW_POS: begin
				num = NUM_W'({ctx_in.ux, 1'b0});
				den = DEN_W'(rsum);
			end
			K_BELOW_NEG: begin
				num = NUM_W'(rsum);
				den = DEN_W'(ctx_in.accel);
			end
			K_TOP: begin
				num = ctx_in.top_num;
				den = ctx_in.top_den;
			end
			default: begin
				num = '0;
				den = DEN_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= ctx_in.kind;
			num_s1  <= num;
			den_s1  <= den;
		end
	end

	// the quotient overflows 32 bits exactly when the upper dividend part reaches the divisor
	always_comb begin
		nscaled = {num_s1, {FRAC_BITS{1'b0}}};
		nhigh   = nscaled[NW-1:QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			den_s2  <= den_s1;
			sat_s2  <= (64'(nhigh) >= 64'(den_s1));
			rem_s2  <= 64'(nhigh);
			low_s2  <= nscaled[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s[DIV_STEPS-1];
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic             vld_cur, sat_cur, ge;
		ttg_kind_t        kind_cur;
		logic [DEN_W-1:0] den_cur;
		logic [63:0]      rem_cur, rem_sh, rem_nxt;
		logic [64:0]      diff;
		logic [QW-1:0]    quo_cur, low_cur;

		if (k == 0) begin : g_head
			assign vld_cur  = vld_s2;
			assign sat_cur  = sat_s2;
			assign kind_cur = kind_s2;
			assign den_cur  = den_s2;
			assign rem_cur  = rem_s2;
			assign quo_cur  = '0;
			assign low_cur  = low_s2;
		end else begin : g_body
			assign vld_cur  = vld_s[k-1];
			assign sat_cur  = sat_s[k-1];
			assign kind_cur = kind_s[k-1];
			assign den_cur  = den_s[k-1];
			assign rem_cur  = rem_s[k-1];
			assign quo_cur  = quo_s[k-1];
			assign low_cur  = low_s[k-1];
		end

		always_comb begin
			rem_sh  = {rem_cur[62:0], low_cur[QW-1-k]};
			diff    = {1'b0, rem_sh} - {2'b00, den_cur};
			ge      = !diff[64];
			rem_nxt = ge ? diff[63:0] : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_cur;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[k]  <= sat_cur;
				kind_s[k] <= kind_cur;
				den_s[k]  <= den_cur;
				rem_s[k]  <= rem_nxt;
				quo_s[k]  <= {quo_cur[QW-2:0], ge};
				low_s[k]  <= low_cur;
			end
		end
	end

	always_comb begin
		res.time_to_goal  = quo_s[DIV_STEPS-1];
		res.fallback_used = 1'b0;
		res.saturated     = 1'b0;
		case (kind_s[DIV_STEPS-1])
			K_ZERO: res.time_to_goal = '0;
			K_FALLBACK: begin
				res.time_to_goal  = ONE_Q;
				res.fallback_used = 1'b1;
			end
			default: begin
				if (sat_s[DIV_STEPS-1]) begin
					res.time_to_goal = TIME_MAX;
					res.saturated    = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			out_q <= res;
	end

	assign vld_out  = vld_q;
	assign word_out = out_q;

endmodule

### rtl/time_to_goal_trapezoid_unit.sv
// Top level of the trapezoidal time-to-goal unit: configuration registers and pipeline.
// Depends on ttg_pkg, ttg_front, ttg_sqrt and ttg_div.
//
//   channel  direction  handshake            word
//   in       into unit  in_valid / in_stall   ttg_in_t  (distance, speed)
//   out      from unit  out_valid / out_stall ttg_out_t (time_to_goal, flags)
//   cfg      into unit  cfg_we               cfg_index, cfg_data
//
// One word per cycle while no result is stalled; stages: 3 front, 32 square-root,
// 2 operand, 32 divider and the result register.
// A stalled result freezes every stage at once; in_stall is raised only then.
// Reset clears all valid bits and sets each configuration register to 1.0.
module time_to_goal_trapezoid_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ttg_pkg::ttg_in_t              in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ttg_pkg::ttg_out_t             out_word,
	input  logic                          cfg_we,
	input  logic [ttg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttg_pkg::REG_W-1:0]     cfg_data
);
	import ttg_pkg::*;

	logic [REG_W-1:0] max_speed_q, accel_toward_q, accel_away_q;
	logic             en;
	logic             vld_f, vld_r;
	ttg_ctx_t         ctx_f, ctx_r;
	logic [RAD_W-1:0] rad_f;
	logic [QW-1:0]    root_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q    <= ONE_Q[REG_W-1:0];
			accel_toward_q <= ONE_Q[REG_W-1:0];
			accel_away_q   <= ONE_Q[REG_W-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_SPEED:    max_speed_q    <= cfg_data;
				REG_ACCEL_TOWARD: accel_toward_q <= cfg_data;
				REG_ACCEL_AWAY:   accel_away_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the whole pipeline while a finished word waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	ttg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_in       (in_valid),
		.word_in      (in_word),
		.max_speed    (max_speed_q),
		.accel_toward (accel_toward_q),
		.accel_away   (accel_away_q),
		.vld_out      (vld_f),
		.ctx_out      (ctx_f),
		.rad_out      (rad_f)
	);

	ttg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_f),
		.ctx_in   (ctx_f),
		.rad_in   (rad_f),
		.vld_out  (vld_r),
		.ctx_out  (ctx_r),
		.root_out (root_r)
	);

	ttg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_r),
		.ctx_in   (ctx_r),
		.root_in  (root_r),
		.vld_out  (out_valid),
		.word_out (out_word)
	);

endmodule

### rtl/ttg_checker.sv
// Port-level checks for the time-to-goal unit, bound to the top level.
// Depends on ttg_pkg.
module ttg_assertions (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input ttg_pkg::ttg_in_t              in_word,
	input logic                          out_valid,
	input logic                          out_stall,
	input ttg_pkg::ttg_out_t             out_word,
	input logic                          cfg_we,
	input logic [ttg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ttg_pkg::REG_W-1:0]     cfg_data
);
	import ttg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.fallback_used && out_word.saturated))
		else $error("fallback and saturation both set");

	a_fallback_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.fallback_used |-> out_word.time_to_goal == ONE_Q)
		else $error("fallback time is not 1.0");

	a_sat_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.saturated |-> out_word.time_to_goal == TIME_MAX)
		else $error("saturated time is not the maximum");

endmodule

bind time_to_goal_trapezoid_unit ttg_assertions u_ttg_assertions (.*);

### sim/ttg_checker.sv
// Checker for the trapezoidal time-to-goal unit: tracks register writes, predicts
// the result of every accepted input word and compares it with the output channel.
// Depends on ttg_pkg.
module ttg_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  ttg_pkg::ttg_in_t              in_word,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  ttg_pkg::ttg_out_t             out_word,
	input  logic                          cfg_we,
	input  logic [ttg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttg_pkg::REG_W-1:0]     cfg_data,
	output int                            pending,
	output int                            errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import ttg_pkg::*;

	logic [63:0] top_speed, acc_toward, acc_away;
	ttg_out_t    expected_times[$];

	initial begin
		pending = 0;
		errors  = 0;
	end

	function automatic logic [63:0] int_root(logic [63:0] s);
		logic [63:0]  r;
		logic [63:0]  cand;
		logic [127:0] sq;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			sq   = {64'b0, cand} * {64'b0, cand};
			if (sq <= {64'b0, s})
				r = cand;
		end
		return r;
	endfunction

	function automatic ttg_out_t predict_time(ttg_in_t w);
		longint       x, v;
		logic [63:0]  a, ux, mag, v1, r, dv;
		logic [127:0] s, num, den, q;
		ttg_out_t     o;
		o = '0;
		x = longint'($signed(w.distance));
		v = longint'($signed(w.speed));
		a = acc_toward;
		if (x == 0)
			return o;
		// mirror a negative distance
		if (x < 0) begin
			x = -x;
			v = -v;
			a = acc_away;
		end
		ux  = x;
		mag = (v < 0) ? -v : v;
		if (a == 0) begin
			if (v <= 0) begin
				o.time_to_goal  = ONE_Q;
				o.fallback_used = 1'b1;
				return o;
			end
			num = 128'(ux);
			den = 128'(mag);
		end else begin
			v1 = top_speed;
			if (v > 0 && mag > v1)
				v1 = mag;
			if (v1 == 0)
				v1 = 64'(ONE_Q);
			s = {64'b0, mag} * mag + 2 * {64'b0, a} * ux;
			if (s <= {64'b0, v1} * v1) begin
				r = int_root(s[63:0]);
				if (v >= 0) begin
					num = 2 * {64'b0, ux};
					den = {64'b0, r} + mag;
				end else begin
					num = {64'b0, r} + mag;
					den = 128'(a);
				end
			end else begin
				dv  = (v >= 0) ? v1 - mag : v1 + mag;
				num = {64'b0, dv} * dv + 2 * {64'b0, a} * ux;
				den = 2 * {64'b0, a} * v1;
			end
		end
		q = (num << FRAC_BITS) / den;
		if (q > {96'b0, TIME_MAX}) begin
			o.time_to_goal = TIME_MAX;
			o.saturated    = 1'b1;
		end else begin
			o.time_to_goal = q[31:0];
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ttg_out_t e;
		if (!arst_n) begin
			top_speed  <= 64'(ONE_Q);
			acc_toward <= 64'(ONE_Q);
			acc_away   <= 64'(ONE_Q);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_SPEED:    top_speed  <= 64'(cfg_data);
					REG_ACCEL_TOWARD: acc_toward <= 64'(cfg_data);
					REG_ACCEL_AWAY:   acc_away   <= 64'(cfg_data);
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_times.push_back(predict_time(in_word));
			if (out_valid && !out_stall) begin
				if (expected_times.size() == 0) begin
					$display("%0t: unexpected word time=%h fb=%b sat=%b", $time,
						out_word.time_to_goal, out_word.fallback_used, out_word.saturated);
					errors++;
				end else begin
					e = expected_times.pop_front();
					if (e.time_to_goal !== out_word.time_to_goal) begin
						$display("%0t: time_to_goal expected %h actual %h", $time,
							e.time_to_goal, out_word.time_to_goal);
						errors++;
					end
					if (e.fallback_used !== out_word.fallback_used) begin
						$display("%0t: fallback_used expected %b actual %b", $time,
							e.fallback_used, out_word.fallback_used);
						errors++;
					end
					if (e.saturated !== out_word.saturated) begin
						$display("%0t: saturated expected %b actual %b", $time,
							e.saturated, out_word.saturated);
						errors++;
					end
				end
			end
			pending = expected_times.size();
		end
	end

endmodule

### sim/tb_top.sv
// Testbench top for the trapezoidal time-to-goal unit: clock, reset, register
// settings, directed and random words, idle and stall patterns, verdict.
// Depends on ttg_pkg, ttg_checker and the unit's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ttg_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_stall;
	ttg_in_t              in_word = '0;
	logic                 out_valid;
	logic                 out_stall = 0;
	ttg_out_t             out_word;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_SPEED;
	logic [REG_W-1:0]     cfg_data = '0;
	int                   pending, errors;

	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_seq  = 0;
	int hold_seen = 0;
	int hold_cnt  = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	time_to_goal_trapezoid_unit u_top (.*);

	ttg_checker u_chk (.*);

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_cnt  = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_word(ttg_in_t w);
		logic st;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] signed_mag(logic [31:0] m);
		return $urandom_range(1) ? -m : m;
	endfunction

	function automatic ttg_in_t rand_word();
		ttg_in_t w;
		logic [31:0] specials[8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
			32'h1, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001};
		case ($urandom_range(9))
			0, 1, 2: begin
				w.distance = $urandom;
				w.speed    = $urandom;
			end
			3, 4, 5, 6: begin
				w.distance = signed_mag($urandom_range(32'h0010_0000));
				w.speed    = signed_mag($urandom_range(32'h0008_0000));
			end
			7: begin
				w.distance = specials[$urandom_range(7)];
				w.speed    = $urandom_range(1) ? specials[$urandom_range(7)] : $urandom;
			end
			default: begin
				w.distance = signed_mag($urandom_range(32'h0400_0000));
				w.speed    = signed_mag($urandom_range(32'h0100_0000));
			end
		endcase
		return w;
	endfunction

	initial begin
		ttg_in_t d;
		logic [31:0] dir_d[11] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1,
			32'h0001_0000, 32'hFFFF_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0100,
			32'h0002_0000};
		logic [31:0] dir_v[11] = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'hFFFF_FFFF, 32'h0003_0000, 32'h0003_0000, 32'hFFF0_0000, 32'h0,
			32'h0000_8000, 32'hFFFE_0000};
		logic [REG_W-1:0] s_max[5] = '{31'h0001_0000, 31'h0, 31'h7FFF_FFFF, 31'h0,
			31'h0002_0000};
		logic [REG_W-1:0] s_acc_t[5] = '{31'h0001_0000, 31'h0, 31'h7FFF_FFFF,
			31'h0000_4000, 31'h0};
		logic [REG_W-1:0] s_acc_a[5] = '{31'h0001_0000, 31'h7FFF_FFFF, 31'h0, 31'h1,
			31'h0008_0000};
		int idle_mode[5] = '{0, 78, 0, 16, 78};
		int stall_mode[5] = '{0, 0, 78, 16, 78};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				drain();
				s_max[p]   = (p == 4) ? REG_W'($urandom) : s_max[p];
				write_reg(REG_MAX_SPEED, s_max[p]);
				write_reg(REG_ACCEL_TOWARD, s_acc_t[p]);
				write_reg(REG_ACCEL_AWAY, s_acc_a[p]);
			end
			idle_pct  = idle_mode[p];
			stall_pct = stall_mode[p];
			// fill the pipe while the receiver holds off
			if (p == 2)
				hold_seq++;
			if (p < 2) begin
				for (int i = 0; i < 11; i++) begin
					d.distance = dir_d[i];
					d.speed    = dir_v[i];
					send_word(d);
				end
			end
			for (int i = 0; i < 185; i++)
				send_word(rand_word());
		end
		idle_pct  = 0;
		stall_pct = 0;
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/ttg_pkg.sv
rtl/ttg_front.sv
rtl/ttg_sqrt.sv
rtl/ttg_div.sv
rtl/time_to_goal_trapezoid_unit.sv
rtl/ttg_checker.sv
sim/ttg_checker.sv
sim/tb_top.sv
